/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that drop out of synthesis builds
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/pecs_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pecs_pkg
// shared types, codes and helpers of the edge-cut statistics unit
// ---------------------------------------------------------------------------
package pecs_pkg;

   localparam int CNT_W    = 32;
   localparam int COLOUR_W = 16;
   localparam int KREG_W   = 4;
   localparam int SEL_W    = 3;
   localparam int CMD_W    = 2;

   localparam logic [KREG_W-1:0] K_RESET = 4'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ENTRY = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_code_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic lookup;
      logic update;
      logic push;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fold_done;
   } dp_status_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

/* src/pecs_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pecs_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module pecs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

/* src/pecs_fold.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// pecs_fold
// bit-serial colour fold: (c / k) % k for c >= k, else c
// ---------------------------------------------------------------------------
module pecs_fold #(
   parameter int CW = 16,
   parameter int KW = 4,
   parameter int IW = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [CW-1:0] operand,
   input  logic [KW-1:0] divisor,
   output logic          done,
   output logic [IW-1:0] result
);

   localparam int CNTW = $clog2(CW);
   localparam int GW   = (CW > KW) ? CW : KW;

   logic [CW-1:0]   dividend_ff, dividend_in;
   logic [KW-1:0]   rem_ff, rem_in;
   logic [KW-1:0]   mod_ff, mod_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            ge_ff, ge_in;
   logic [IW-1:0]   small_ff, small_in;
   logic [KW:0]     rem_sh;
   logic [KW:0]     mod_sh;
   logic            q_bit;
   logic            last_step;

   always_comb begin
      rem_sh    = {rem_ff, dividend_ff[CW-1]};
      q_bit     = (rem_sh >= {1'b0, k_ff});
      // quotient bits feed a running remainder, so the modulo needs no second pass
      mod_sh    = {mod_ff, q_bit};
      last_step = busy_ff && (cnt_ff == CNTW'(CW - 1));

      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      mod_in      = mod_ff;
      k_in        = k_ff;
      cnt_in      = cnt_ff;
      busy_in     = busy_ff;
      ge_in       = ge_ff;
      small_in    = small_ff;

      if (start) begin
         dividend_in = operand;
         rem_in      = '0;
         mod_in      = '0;
         k_in        = divisor;
         cnt_in      = '0;
         busy_in     = 1'b1;
         ge_in       = (GW'(operand) >= GW'(divisor));
         small_in    = IW'(operand);
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[CW-2:0], 1'b0};
         rem_in      = q_bit ? KW'(rem_sh - {1'b0, k_ff}) : KW'(rem_sh);
         mod_in      = (mod_sh >= {1'b0, k_ff}) ? KW'(mod_sh - {1'b0, k_ff}) : KW'(mod_sh);
         cnt_in      = cnt_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      mod_ff      <= mod_in;
      k_ff        <= k_in;
      ge_ff       <= ge_in;
      small_ff    <= small_in;
   end

   assign done   = last_step;
   assign result = ge_ff ? IW'(mod_ff) : small_ff;

   `ASSERT_IMP(a_no_restart_busy, clock, reset, start, !busy_ff)

endmodule

/* src/pecs_datapath.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// pecs_datapath
// item latch, colour folding, pair table, counters and result register
// ---------------------------------------------------------------------------
module pecs_datapath #(
   parameter int MAX_SUBGRAPHS = 8,
   parameter int COLOUR_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [pecs_pkg::KREG_W-1:0]          csr_write_data,
   input  logic [pecs_pkg::CMD_W-1:0]           req_command,
   input  logic [pecs_pkg::COLOUR_W-1:0]        req_vertex_colour,
   input  logic [pecs_pkg::COLOUR_W-1:0]        req_neighbour_colour,
   input  logic                                 req_has_neighbour,
   input  logic                                 req_last_of_vertex,
   input  logic [pecs_pkg::SEL_W-1:0]           req_read_row,
   input  logic [pecs_pkg::SEL_W-1:0]           req_read_col,
   input  pecs_pkg::ctrl_cmd_type               cmd,
   output pecs_pkg::dp_status_type              status,
   output logic [pecs_pkg::CNT_W-1:0]           rsp_pair_edges,
   output logic [pecs_pkg::CNT_W-1:0]           rsp_row_vertices,
   output logic [pecs_pkg::CNT_W-1:0]           rsp_lonely_vertices,
   output logic [pecs_pkg::CNT_W-1:0]           rsp_cut_entries,
   output logic [pecs_pkg::CNT_W-1:0]           rsp_total_entries
);

   localparam int CNT_W = pecs_pkg::CNT_W;
   localparam int MB    = (COLOUR_BITS < pecs_pkg::COLOUR_W) ? COLOUR_BITS
                                                             : pecs_pkg::COLOUR_W;
   localparam int IW    = $clog2(MAX_SUBGRAPHS);
   localparam int KW    = $clog2(MAX_SUBGRAPHS + 1);
   localparam int DEPTH = MAX_SUBGRAPHS * MAX_SUBGRAPHS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RCW   = (KW > pecs_pkg::SEL_W) ? KW : pecs_pkg::SEL_W;

   logic [pecs_pkg::KREG_W-1:0] k_reg_ff, k_reg_in;
   pecs_pkg::cmd_code_type      cmd_ff, cmd_in;
   logic [MB-1:0]               vc_ff, vc_in;
   logic [MB-1:0]               nc_ff, nc_in;
   logic                        has_n_ff, has_n_in;
   logic                        last_ff, last_in;
   logic [pecs_pkg::SEL_W-1:0]  row_ff, row_in;
   logic [pecs_pkg::SEL_W-1:0]  col_ff, col_in;
   logic [AW-1:0]               addr_ff, addr_in;
   logic [DEPTH-1:0]            valid_ff, valid_in;
   logic [CNT_W-1:0]            counts_ff [MAX_SUBGRAPHS];
   logic [CNT_W-1:0]            counts_in [MAX_SUBGRAPHS];
   logic                        seen_ff, seen_in;
   logic [CNT_W-1:0]            lonely_ff, lonely_in;
   logic [CNT_W-1:0]            cut_ff, cut_in;
   logic [CNT_W-1:0]            entry_ff, entry_in;
   logic [CNT_W-1:0]            res_pair_ff, res_pair_in;
   logic [CNT_W-1:0]            res_row_ff, res_row_in;
   logic [CNT_W-1:0]            out_pair_ff, out_pair_in;
   logic [CNT_W-1:0]            out_row_ff, out_row_in;
   logic [CNT_W-1:0]            out_lonely_ff, out_lonely_in;
   logic [CNT_W-1:0]            out_cut_ff, out_cut_in;
   logic [CNT_W-1:0]            out_entry_ff, out_entry_in;

   logic [KW-1:0]    k_eff;
   logic             fold_start;
   logic             v_done;
   logic             n_done;
   logic [IW-1:0]    v_fold;
   logic [IW-1:0]    n_fold;
   logic             row_ok;
   logic             col_ok;
   logic [AW-1:0]    entry_addr;
   logic [AW-1:0]    read_addr;
   logic [AW-1:0]    lookup_addr;
   logic [CNT_W-1:0] ram_q;
   logic [CNT_W-1:0] pair_q;
   logic [CNT_W-1:0] pair_q_inc;
   logic [IW-1:0]    cnt_idx;
   logic [CNT_W-1:0] cnt_rd;
   logic             seen_now;
   logic             ram_we;

   // register value 0 means one colour, anything above the table size is clamped
   always_comb begin
      if (k_reg_ff == '0) begin
         k_eff = KW'(1);
      end else if (int'(k_reg_ff) > MAX_SUBGRAPHS) begin
         k_eff = KW'(MAX_SUBGRAPHS);
      end else begin
         k_eff = KW'(k_reg_ff);
      end
   end

   assign fold_start = cmd.load &&
                       (pecs_pkg::cmd_code_type'(req_command) == pecs_pkg::CMD_ENTRY);

   pecs_fold #(
      .CW (MB),
      .KW (KW),
      .IW (IW)
   ) u_fold_vertex (
      .clock   (clock),
      .reset   (reset),
      .start   (fold_start),
      .operand (MB'(req_vertex_colour)),
      .divisor (k_eff),
      .done    (v_done),
      .result  (v_fold)
   );

   pecs_fold #(
      .CW (MB),
      .KW (KW),
      .IW (IW)
   ) u_fold_neighbour (
      .clock   (clock),
      .reset   (reset),
      .start   (fold_start),
      .operand (MB'(req_neighbour_colour)),
      .divisor (k_eff),
      .done    (n_done),
      .result  (n_fold)
   );

   assign status.fold_done = v_done && n_done;

   always_comb begin
      row_ok      = (RCW'(row_ff) < RCW'(k_eff));
      col_ok      = (RCW'(col_ff) < RCW'(k_eff));
      entry_addr  = AW'(v_fold) * AW'(MAX_SUBGRAPHS) + AW'(n_fold);
      read_addr   = (row_ok && col_ok) ? AW'(row_ff) * AW'(MAX_SUBGRAPHS) + AW'(col_ff)
                                       : '0;
      lookup_addr = (cmd_ff == pecs_pkg::CMD_READ) ? read_addr : entry_addr;
      // cells never written since reset or clear read as zero
      pair_q      = valid_ff[addr_ff] ? ram_q : '0;
      pair_q_inc  = pecs_pkg::sat_inc(pair_q);
      cnt_idx     = (cmd_ff == pecs_pkg::CMD_READ) ? IW'(row_ff) : v_fold;
      cnt_rd      = counts_ff[cnt_idx];
      seen_now    = seen_ff || (has_n_ff && (v_fold == n_fold));
      ram_we      = cmd.update && (cmd_ff == pecs_pkg::CMD_ENTRY) && has_n_ff;
   end

   pecs_ram #(
      .WIDTH (CNT_W),
      .DEPTH (DEPTH)
   ) u_pair_ram (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (addr_ff),
      .write_data    (pair_q_inc),
      .read_address  (lookup_addr),
      .read_data     (ram_q)
   );

   always_comb begin
      k_reg_in      = csr_write_enable ? csr_write_data : k_reg_ff;
      cmd_in        = cmd_ff;
      vc_in         = vc_ff;
      nc_in         = nc_ff;
      has_n_in      = has_n_ff;
      last_in       = last_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      addr_in       = cmd.lookup ? lookup_addr : addr_ff;
      valid_in      = valid_ff;
      counts_in     = counts_ff;
      seen_in       = seen_ff;
      lonely_in     = lonely_ff;
      cut_in        = cut_ff;
      entry_in      = entry_ff;
      res_pair_in   = res_pair_ff;
      res_row_in    = res_row_ff;
      out_pair_in   = out_pair_ff;
      out_row_in    = out_row_ff;
      out_lonely_in = out_lonely_ff;
      out_cut_in    = out_cut_ff;
      out_entry_in  = out_entry_ff;

      if (cmd.load) begin
         cmd_in   = pecs_pkg::cmd_code_type'(req_command);
         vc_in    = MB'(req_vertex_colour);
         nc_in    = MB'(req_neighbour_colour);
         has_n_in = req_has_neighbour;
         last_in  = req_last_of_vertex;
         row_in   = req_read_row;
         col_in   = req_read_col;
      end

      if (cmd.update) begin
         res_pair_in = '0;
         res_row_in  = '0;
         unique case (cmd_ff)
            pecs_pkg::CMD_CLEAR: begin
               valid_in  = '0;
               counts_in = '{default: '0};
               seen_in   = 1'b0;
               lonely_in = '0;
               cut_in    = '0;
               entry_in  = '0;
            end
            pecs_pkg::CMD_ENTRY: begin
               if (has_n_ff) begin
                  valid_in[addr_ff] = 1'b1;
                  entry_in          = pecs_pkg::sat_inc(entry_ff);
                  // cut test uses the raw colours, not the folded ones
                  if ((k_eff != KW'(1)) && (vc_ff != nc_ff)) begin
                     cut_in = pecs_pkg::sat_inc(cut_ff);
                  end
               end
               if (last_ff) begin
                  if (!seen_now) begin
                     lonely_in = pecs_pkg::sat_inc(lonely_ff);
                  end
                  counts_in[v_fold] = pecs_pkg::sat_inc(cnt_rd);
                  seen_in           = 1'b0;
               end else begin
                  seen_in = seen_now;
               end
            end
            pecs_pkg::CMD_READ: begin
               if (row_ok && col_ok) begin
                  res_pair_in = (row_ff == col_ff) ? (pair_q >> 1) : pair_q;
               end
               if (row_ok) begin
                  res_row_in = cnt_rd;
               end
            end
            pecs_pkg::CMD_NONE: begin
               res_pair_in = '0;
            end
         endcase
      end

      if (cmd.push) begin
         out_pair_in   = res_pair_ff;
         out_row_in    = res_row_ff;
         out_lonely_in = lonely_ff;
         out_cut_in    = cut_ff;
         out_entry_in  = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_reg_ff  <= pecs_pkg::K_RESET;
         valid_ff  <= '0;
         counts_ff <= '{default: '0};
         seen_ff   <= 1'b0;
         lonely_ff <= '0;
         cut_ff    <= '0;
         entry_ff  <= '0;
      end else begin
         k_reg_ff  <= k_reg_in;
         valid_ff  <= valid_in;
         counts_ff <= counts_in;
         seen_ff   <= seen_in;
         lonely_ff <= lonely_in;
         cut_ff    <= cut_in;
         entry_ff  <= entry_in;
      end
      cmd_ff        <= cmd_in;
      vc_ff         <= vc_in;
      nc_ff         <= nc_in;
      has_n_ff      <= has_n_in;
      last_ff       <= last_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      addr_ff       <= addr_in;
      res_pair_ff   <= res_pair_in;
      res_row_ff    <= res_row_in;
      out_pair_ff   <= out_pair_in;
      out_row_ff    <= out_row_in;
      out_lonely_ff <= out_lonely_in;
      out_cut_ff    <= out_cut_in;
      out_entry_ff  <= out_entry_in;
   end

   assign rsp_pair_edges      = out_pair_ff;
   assign rsp_row_vertices    = out_row_ff;
   assign rsp_lonely_vertices = out_lonely_ff;
   assign rsp_cut_entries     = out_cut_ff;
   assign rsp_total_entries   = out_entry_ff;

   `ASSERT_NXT(a_clear_empties, clock, reset, cmd.update && cmd_ff == pecs_pkg::CMD_CLEAR, entry_ff == '0 && valid_ff == '0 && !seen_ff)

endmodule

/* src/pecs_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// pecs_ctrl
// sequencer for one beat at a time: fold, table lookup, update, result
// ---------------------------------------------------------------------------
module pecs_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [pecs_pkg::CMD_W-1:0]   req_command,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  pecs_pkg::dp_status_type      status,
   output pecs_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_FOLD   = 5'b00010,
      ST_LOOKUP = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_OUTPUT = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (pecs_pkg::cmd_code_type'(req_command)) inside
                  pecs_pkg::CMD_ENTRY:                     state_in = ST_FOLD;
                  pecs_pkg::CMD_READ:                      state_in = ST_LOOKUP;
                  pecs_pkg::CMD_CLEAR, pecs_pkg::CMD_NONE: state_in = ST_UPDATE;
               endcase
            end
         end
         ST_FOLD: begin
            if (status.fold_done) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_IMP(a_push_only_free, clock, reset, cmd.push, !rsp_valid_ff || rsp_ready)
   `ASSERT_NXT(a_single_item, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_NXT(a_push_shows_result, clock, reset, cmd.push, rsp_valid)

endmodule

/* src/partition_edge_cut_statistics_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// partition_edge_cut_statistics_unit
// edge-cut and pair histogram statistics over a streamed, coloured graph
// ---------------------------------------------------------------------------
// Every request beat returns exactly one response beat, in order. An adjacency
// entry has both colours folded in parallel by bit-serial dividers that take
// one quotient bit per cycle, followed by the pair ram read, the counter update
// and loading the response register, after which rsp_valid rises. A read
// command skips the fold, and a clear or unused command skips the fold and the
// ram read. The sequencer returns to its idle state after each response is
// loaded and takes the next beat only there. One beat is worked on at a time;
// the response register holds a finished result while the next beat is
// accepted, and a stalled response holds the sequencer in its output state,
// blocking the next result from being loaded and any further beat from being
// accepted until then.
// Cleared and never-written table cells are tracked by a valid bit per cell,
// so there is no clearing sweep after reset or a clear command.
module partition_edge_cut_statistics_unit #(
   parameter int MAX_SUBGRAPHS = 8,
   parameter int COLOUR_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,

   // subgraph count register
   input  logic                                 csr_write_enable,
   input  logic [pecs_pkg::KREG_W-1:0]          csr_write_data,

   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pecs_pkg::CMD_W-1:0]           req_command,
   input  logic [pecs_pkg::COLOUR_W-1:0]        req_vertex_colour,
   input  logic [pecs_pkg::COLOUR_W-1:0]        req_neighbour_colour,
   input  logic                                 req_has_neighbour,
   input  logic                                 req_last_of_vertex,
   input  logic [pecs_pkg::SEL_W-1:0]           req_read_row,
   input  logic [pecs_pkg::SEL_W-1:0]           req_read_col,

   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pecs_pkg::CNT_W-1:0]           rsp_pair_edges,
   output logic [pecs_pkg::CNT_W-1:0]           rsp_row_vertices,
   output logic [pecs_pkg::CNT_W-1:0]           rsp_lonely_vertices,
   output logic [pecs_pkg::CNT_W-1:0]           rsp_cut_entries,
   output logic [pecs_pkg::CNT_W-1:0]           rsp_total_entries
);

   pecs_pkg::ctrl_cmd_type  cmd;
   pecs_pkg::dp_status_type status;

   // sequencer: takes a beat through fold, lookup, update, output as needed
   pecs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   // colour folding, pair ram, saturating counters and response register
   pecs_datapath #(
      .MAX_SUBGRAPHS (MAX_SUBGRAPHS),
      .COLOUR_BITS   (COLOUR_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_command          (req_command),
      .req_vertex_colour    (req_vertex_colour),
      .req_neighbour_colour (req_neighbour_colour),
      .req_has_neighbour    (req_has_neighbour),
      .req_last_of_vertex   (req_last_of_vertex),
      .req_read_row         (req_read_row),
      .req_read_col         (req_read_col),
      .cmd                  (cmd),
      .status               (status),
      .rsp_pair_edges       (rsp_pair_edges),
      .rsp_row_vertices     (rsp_row_vertices),
      .rsp_lonely_vertices  (rsp_lonely_vertices),
      .rsp_cut_entries      (rsp_cut_entries),
      .rsp_total_entries    (rsp_total_entries)
   );

endmodule
